// ===== sv/tpdac_pkg.sv =====
// tpdac_pkg: shared types, codes, constants and the sine table of the
// tone and PCM DAC sample generator. No dependencies.
package tpdac_pkg;

    // Defaults for the top-level parameters
    localparam int TICK_RATE_DEF   = 8000;
    localparam int COUNT_WIDTH_DEF = 24;

    // DAC code range
    localparam logic [11:0] DAC_MID = 12'd2048;
    localparam logic [11:0] DAC_MAX = 12'd4095;

    // Volume gain: floor(x * VOL_RECIP >> VOL_SHIFT) == floor(x / 100) for x < 2^18
    localparam int          VOL_SHIFT = 25;
    localparam int          GAIN_W    = 26;
    localparam logic [18:0] VOL_RECIP = 19'd335545;
    localparam logic [6:0]  VOL_FULL  = 7'd100;
    localparam logic [6:0]  VOL_RST   = 7'd50;

    // Register reset values
    localparam logic [11:0] FREQ_RST = 12'd1000;
    localparam logic [23:0] PLAY_RST = 24'd8000;

    // Input word codes
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    // Source select codes
    typedef enum logic [1:0] {
        SRC_SINE  = 2'd0,
        SRC_PCM8  = 2'd1,
        SRC_PCM12 = 2'd2
    } src_t;

    // Register indexes (byte address bits 3:2)
    typedef enum logic [1:0] {
        REG_SOURCE = 2'd0,
        REG_VOLUME = 2'd1,
        REG_FREQ   = 2'd2,
        REG_PLAY   = 2'd3
    } reg_idx_t;

    // Request to the volume scaler
    typedef struct packed {
        logic signed [11:0] centred; // sample minus its midpoint
        logic               narrow;  // 8-bit source: result is boosted by 16
    } scale_req_t;

    // Sine table, unsigned 8-bit centred on 128
    localparam logic [7:0] SINE_ROM [256] = '{
        8'd128,8'd131,8'd134,8'd137,8'd140,8'd143,8'd146,8'd149,
        8'd152,8'd155,8'd158,8'd162,8'd165,8'd168,8'd170,8'd173,
        8'd176,8'd179,8'd182,8'd184,8'd187,8'd190,8'd192,8'd195,
        8'd197,8'd200,8'd202,8'd204,8'd207,8'd209,8'd211,8'd213,
        8'd215,8'd217,8'd219,8'd221,8'd223,8'd225,8'd226,8'd228,
        8'd230,8'd231,8'd233,8'd234,8'd235,8'd237,8'd238,8'd239,
        8'd240,8'd241,8'd242,8'd243,8'd244,8'd244,8'd245,8'd246,
        8'd246,8'd247,8'd247,8'd248,8'd248,8'd248,8'd248,8'd248,
        8'd255,8'd248,8'd248,8'd248,8'd248,8'd248,8'd247,8'd247,
        8'd246,8'd246,8'd245,8'd244,8'd244,8'd243,8'd242,8'd241,
        8'd240,8'd239,8'd238,8'd237,8'd235,8'd234,8'd233,8'd231,
        8'd230,8'd228,8'd226,8'd225,8'd223,8'd221,8'd219,8'd217,
        8'd215,8'd213,8'd211,8'd209,8'd207,8'd204,8'd202,8'd200,
        8'd197,8'd195,8'd192,8'd190,8'd187,8'd184,8'd182,8'd179,
        8'd176,8'd173,8'd170,8'd168,8'd165,8'd162,8'd158,8'd155,
        8'd152,8'd149,8'd146,8'd143,8'd140,8'd137,8'd134,8'd131,
        8'd128,8'd125,8'd122,8'd119,8'd116,8'd113,8'd110,8'd107,
        8'd104,8'd101,8'd98, 8'd94, 8'd91, 8'd88, 8'd86, 8'd83,
        8'd80, 8'd77, 8'd74, 8'd72, 8'd69, 8'd66, 8'd64, 8'd61,
        8'd59, 8'd56, 8'd54, 8'd52, 8'd49, 8'd47, 8'd45, 8'd43,
        8'd41, 8'd39, 8'd37, 8'd35, 8'd33, 8'd31, 8'd30, 8'd28,
        8'd26, 8'd25, 8'd23, 8'd22, 8'd21, 8'd19, 8'd18, 8'd17,
        8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd12, 8'd11, 8'd10,
        8'd10, 8'd9,  8'd9,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,
        8'd0,  8'd8,  8'd8,  8'd8,  8'd8,  8'd8,  8'd9,  8'd9,
        8'd10, 8'd10, 8'd11, 8'd12, 8'd12, 8'd13, 8'd14, 8'd15,
        8'd16, 8'd17, 8'd18, 8'd19, 8'd21, 8'd22, 8'd23, 8'd25,
        8'd26, 8'd28, 8'd30, 8'd31, 8'd33, 8'd35, 8'd37, 8'd39,
        8'd41, 8'd43, 8'd45, 8'd47, 8'd49, 8'd52, 8'd54, 8'd56,
        8'd59, 8'd61, 8'd64, 8'd66, 8'd69, 8'd72, 8'd74, 8'd77,
        8'd80, 8'd83, 8'd86, 8'd88, 8'd91, 8'd94, 8'd98, 8'd101,
        8'd104,8'd107,8'd110,8'd113,8'd116,8'd119,8'd122,8'd125
    };

endpackage

// ===== sv/tpdac_in_if.sv =====
// tpdac_in_if: valid/ready channel carrying one input word (mode, PCM sample).
// No dependencies.
interface tpdac_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] pcm_sample;

    modport source (output valid, output mode, output pcm_sample, input ready);
    modport sink   (input valid, input mode, input pcm_sample, output ready);
endinterface

// ===== sv/tpdac_out_if.sv =====
// tpdac_out_if: valid/ready channel carrying one result word (DAC code, flags).
// No dependencies.
interface tpdac_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] dac_code;
    logic        sample_used;
    logic        still_playing;

    modport source (output valid, output dac_code, output sample_used,
                    output still_playing, input ready);
    modport sink   (input valid, input dac_code, input sample_used,
                    input still_playing, output ready);
endinterface

// ===== sv/tone_and_pcm_dac_sample_generator_core.sv =====
// tone_and_pcm_dac_sample_generator_core: top level with APB registers,
// playback state and a skid-buffered result channel.
// Depends on tpdac_pkg, tpdac_in_if, tpdac_out_if and tpdac_scale.
//
// Usage:
//   item   : input words. mode 0 is a sample tick, 1 starts playback of
//            play_length ticks (no result word), 2 stops (one 2048 word),
//            3 is dropped. pcm_sample is read on ticks in PCM modes.
//   result : one word per tick or stop: dac_code, sample_used, still_playing.
//   APB    : four 32-bit registers at 0x0 source, 0x4 volume, 0x8 frequency,
//            0xC play length; pready is tied high, reads are combinational.
// Results are registered, in the result or (while it is held) skid register.
// One word is accepted every cycle while item.ready is high; the sine lookup,
// the volume multiply and the tick counter are combinational ahead of them.
// A two-entry output (result register plus skid register) keeps item ready
// while one result waits; item.ready drops only when both entries are full.
// The tone phase step and the volume gain are computed at register write.
// Reset (rst_n low) empties the output, stops playback, clears the phase
// and count, and loads the register reset values.
module tone_and_pcm_dac_sample_generator_core
    import tpdac_pkg::*;
#(
    parameter int TICK_RATE   = TICK_RATE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    tpdac_in_if.sink      item,
    tpdac_out_if.source   result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // Phase step = max(1, floor(f*256/TICK_RATE)) via an exact reciprocal
    localparam int          STEP_SHIFT = 21 + $clog2(TICK_RATE);
    localparam longint      RECIP_L    = ((64'd1 <<< STEP_SHIFT) + TICK_RATE - 1)
                                         / TICK_RATE;
    localparam logic [31:0] STEP_RECIP = 32'(RECIP_L);
    localparam int          STEP_RAW   = 1000 * 256 / TICK_RATE;
    localparam logic [15:0] STEP_RST   = (STEP_RAW == 0) ? 16'd1 : 16'(STEP_RAW);
    localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(VOL_RST) * GAIN_W'(VOL_RECIP);

    // Configuration registers
    logic [1:0]              src_reg;
    logic [6:0]              vol_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [11:0]             freq_reg;
    logic [15:0]             step_reg;
    logic [23:0]             play_reg;

    // Playback state
    logic [15:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]  ticks_reg, ticks_next;
    logic                    active_reg, active_next;

    // Output register and skid register
    logic                    out_valid_reg, skid_valid_reg;
    logic [11:0]             out_code_reg, skid_code_reg;
    logic                    out_used_reg, skid_used_reg;
    logic                    out_play_reg, skid_play_reg;

    logic                    cfg_wr;
    logic [6:0]              vol_sat;
    logic [51:0]             step_prod;
    logic [15:0]             step_q;
    logic [15:0]             step_new;
    logic [GAIN_W-1:0]       gain_new;

    logic                    in_fire;
    logic                    out_take;
    mode_t                   mode;
    logic                    running;
    logic                    produce;
    logic [COUNT_WIDTH-1:0]  play_len;
    scale_req_t              sreq;
    logic [7:0]              sine_raw;
    logic [11:0]             scaled_code;
    logic [11:0]             r_code;
    logic                    r_used;
    logic                    r_play;

    // APB side
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        vol_sat   = (pwdata[6:0] > VOL_FULL) ? VOL_FULL : pwdata[6:0];
        gain_new  = GAIN_W'(vol_sat) * GAIN_W'(VOL_RECIP);
        step_prod = 52'({pwdata[11:0], 8'h00}) * 52'(STEP_RECIP);
        step_q    = 16'(step_prod >> STEP_SHIFT);
        step_new  = (step_q == 16'd0) ? 16'd1 : step_q;
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_SOURCE: prdata = {30'b0, src_reg};
            REG_VOLUME: prdata = {25'b0, vol_reg};
            REG_FREQ:   prdata = {20'b0, freq_reg};
            REG_PLAY:   prdata = {8'b0, play_reg};
            default:    prdata = '0;
        endcase
    end

    // Handshakes
    assign item.ready = !skid_valid_reg;
    assign in_fire    = item.valid && item.ready;
    assign out_take   = out_valid_reg && result.ready;
    assign mode       = mode_t'(item.mode);
    assign running    = active_reg && (ticks_reg != '0);
    assign play_len   = COUNT_WIDTH'(play_reg);

    // Scaler request from the selected source
    assign sine_raw = SINE_ROM[phase_reg[15:8]];

    always_comb
    begin
        sreq.narrow = (src_reg != SRC_PCM12);
        case (src_reg)
            SRC_PCM8:  sreq.centred = {{4{~item.pcm_sample[7]}}, ~item.pcm_sample[7],
                                       item.pcm_sample[6:0]};
            SRC_PCM12: sreq.centred = {~item.pcm_sample[11], item.pcm_sample[10:0]};
            default:   sreq.centred = {{4{~sine_raw[7]}}, ~sine_raw[7], sine_raw[6:0]};
        endcase
    end

    tpdac_scale u_scale
    (
        .req  (sreq),
        .gain (gain_reg),
        .code (scaled_code)
    );

    // Playback state update and result word
    always_comb
    begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        active_next = active_reg;
        produce     = 1'b0;
        r_code      = DAC_MID;
        r_used      = 1'b0;
        r_play      = 1'b0;
        if (in_fire)
        begin
            unique case (mode)
                MODE_START:
                begin
                    if (play_len != '0)
                    begin
                        ticks_next  = play_len;
                        phase_next  = '0;
                        active_next = 1'b1;
                    end
                end
                MODE_STOP:
                begin
                    produce     = 1'b1;
                    ticks_next  = '0;
                    active_next = 1'b0;
                end
                MODE_TICK:
                begin
                    produce = 1'b1;
                    if (running)
                    begin
                        case (src_reg)
                            SRC_SINE:
                            begin
                                phase_next = phase_reg + step_reg;
                                r_code     = scaled_code;
                            end
                            SRC_PCM8, SRC_PCM12:
                            begin
                                r_code = scaled_code;
                                r_used = 1'b1;
                            end
                            default: r_code = DAC_MID;
                        endcase
                        ticks_next  = ticks_reg - COUNT_WIDTH'(1);
                        active_next = (ticks_reg != COUNT_WIDTH'(1));
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                    r_play = active_next;
                end
                default: produce = 1'b0;
            endcase
        end
    end

    // All registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg        <= SRC_SINE;
            vol_reg        <= VOL_RST;
            gain_reg       <= GAIN_RST;
            freq_reg       <= FREQ_RST;
            step_reg       <= STEP_RST;
            play_reg       <= PLAY_RST;
            phase_reg      <= '0;
            ticks_reg      <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_code_reg   <= '0;
            out_used_reg   <= 1'b0;
            out_play_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
            skid_code_reg  <= '0;
            skid_used_reg  <= 1'b0;
            skid_play_reg  <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_wr)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_SOURCE: src_reg <= pwdata[1:0];
                    REG_VOLUME:
                    begin
                        vol_reg  <= vol_sat;
                        gain_reg <= gain_new;
                    end
                    REG_FREQ:
                    begin
                        freq_reg <= pwdata[11:0];
                        step_reg <= step_new;
                    end
                    REG_PLAY:   play_reg <= pwdata[23:0];
                    default:    play_reg <= play_reg;
                endcase
            end

            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            active_reg <= active_next;

            // result register with skid
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    out_code_reg   <= skid_code_reg;
                    out_used_reg   <= skid_used_reg;
                    out_play_reg   <= skid_play_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (produce)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_code_reg  <= r_code;
                    out_used_reg  <= r_used;
                    out_play_reg  <= r_play;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_code_reg  <= r_code;
                    skid_used_reg  <= r_used;
                    skid_play_reg  <= r_play;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.dac_code      = out_code_reg;
    assign result.sample_used   = out_used_reg;
    assign result.still_playing = out_play_reg;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_active_has_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (ticks_reg != '0))
        else $error("playback active with zero ticks left");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode == MODE_START && play_len != '0) |=> active_reg)
        else $error("start did not arm playback");

    a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode == MODE_STOP) |=> (!active_reg && ticks_reg == '0))
        else $error("stop left playback running");

endmodule

// ===== sv/tpdac_scale.sv =====
// tpdac_scale: volume scaling (truncate toward zero), 8-bit boost, centring
// at midscale and clamping to a 12-bit DAC code. Depends on tpdac_pkg.
module tpdac_scale
    import tpdac_pkg::*;
(
    input  scale_req_t        req,
    input  logic [GAIN_W-1:0] gain,     // volume * VOL_RECIP
    output logic [11:0]       code
);

    logic                      neg;
    logic [11:0]               mag;
    logic [GAIN_W+11:0]        prod;
    logic [11:0]               quot;
    logic signed [12:0]        signed_q;
    logic signed [13:0]        boosted;
    logic signed [14:0]        sum;

    // Magnitude times gain; the shift completes the divide by 100
    always_comb
    begin
        neg      = req.centred[11];
        mag      = neg ? 12'(-req.centred) : 12'(req.centred);
        prod     = (GAIN_W+12)'(mag) * (GAIN_W+12)'(gain);
        quot     = 12'(prod >> VOL_SHIFT);
        signed_q = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // Boost, centre and clamp
    always_comb
    begin
        boosted = req.narrow ? (14'(signed_q) <<< 4) : 14'(signed_q);
        sum     = 15'(boosted) + $signed({3'b000, DAC_MID});
        if (sum < 0)
        begin
            code = '0;
        end
        else if (sum > $signed({3'b000, DAC_MAX}))
        begin
            code = DAC_MAX;
        end
        else
        begin
            code = 12'(sum);
        end
    end

endmodule

// ===== tb/sv/tpdac_sample_checker.sv =====
// tpdac_sample_checker: watches the word channels and the APB port of the
// tone/PCM DAC sample generator, predicts each result word and compares it.
// Depends on tpdac_pkg, tpdac_in_if and tpdac_out_if.
module tpdac_sample_checker
    import tpdac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tpdac_in_if         item,
    tpdac_out_if        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          words_checked
);

    typedef struct packed {
        logic [11:0] dac_code;
        logic        sample_used;
        logic        still_playing;
    } dac_word_t;

    // register copy
    logic [1:0]                 source_sel;
    logic [6:0]                 volume;
    logic [11:0]                tone_freq;
    logic [COUNT_WIDTH_DEF-1:0] play_len;

    // playback state
    logic [15:0]                phase;
    logic [COUNT_WIDTH_DEF-1:0] ticks_left;
    logic                       playing;

    dac_word_t expected_words[$];
    int        mismatch_count;
    int        compared;

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // gain in percent, truncated toward zero
    function automatic int apply_volume(input int centred);
        return (centred * int'(volume)) / 100;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (reg_idx_t'(idx))
            REG_SOURCE: return {30'b0, source_sel};
            REG_VOLUME: return {25'b0, volume};
            REG_FREQ:   return {20'b0, tone_freq};
            default:    return 32'(play_len);
        endcase
    endfunction

    // advance the playback state by one input word, queue the word it yields
    task automatic predict_word(input logic [1:0] mode, input logic [11:0] pcm);
        dac_word_t w;
        int        code;
        int        step;
        code          = int'(DAC_MID);
        w.sample_used = 1'b0;
        case (mode)
            MODE_START:
            begin
                // a zero length leaves everything as it was
                if (play_len != '0)
                begin
                    ticks_left = play_len;
                    phase      = '0;
                    playing    = 1'b1;
                end
            end
            MODE_STOP:
            begin
                playing    = 1'b0;
                ticks_left = '0;
                w.dac_code      = DAC_MID;
                w.still_playing = 1'b0;
                expected_words.push_back(w);
            end
            MODE_TICK:
            begin
                if (playing && ticks_left != '0)
                begin
                    case (source_sel)
                        SRC_SINE:
                        begin
                            step = (int'(tone_freq) * 256) / TICK_RATE_DEF;
                            if (step == 0)
                                step = 1;
                            code = int'(DAC_MID)
                                 + apply_volume(int'(SINE_ROM[phase[15:8]]) - 128) * 16;
                            phase = phase + 16'(step);
                        end
                        SRC_PCM8:
                        begin
                            code = int'(DAC_MID) + apply_volume(int'(pcm[7:0]) - 128) * 16;
                            w.sample_used = 1'b1;
                        end
                        SRC_PCM12:
                        begin
                            code = int'(DAC_MID) + apply_volume(int'(pcm) - int'(DAC_MID));
                            w.sample_used = 1'b1;
                        end
                        default: ;  // unused source: silence, count still runs
                    endcase
                    ticks_left = ticks_left - 1'b1;
                    if (ticks_left == '0)
                        playing = 1'b0;
                end
                else
                begin
                    playing = 1'b0;
                end
                if (code < 0)
                    code = 0;
                else if (code > int'(DAC_MAX))
                    code = int'(DAC_MAX);
                w.dac_code      = code[11:0];
                w.still_playing = playing;
                expected_words.push_back(w);
            end
            default: ;  // unused mode is dropped
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dac_word_t want;
        if (!rst_n)
        begin
            source_sel = SRC_SINE;
            volume     = VOL_RST;
            tone_freq  = FREQ_RST;
            play_len   = PLAY_RST;
            phase      = '0;
            ticks_left = '0;
            playing    = 1'b0;
            expected_words.delete();
            mismatch_count = 0;
            compared       = 0;
            errors        <= 0;
            pending       <= 0;
            words_checked <= 0;
        end
        else
        begin
            // result word first: it always stems from an earlier input word
            if (result.valid && result.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    flag_error($sformatf("result word with none expected: code %0d",
                                         result.dac_code));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result.dac_code !== want.dac_code)
                        flag_error($sformatf("word %0d dac_code got %0d expected %0d",
                                             compared, result.dac_code, want.dac_code));
                    if (result.sample_used !== want.sample_used)
                        flag_error($sformatf("word %0d sample_used got %0b expected %0b",
                                             compared, result.sample_used,
                                             want.sample_used));
                    if (result.still_playing !== want.still_playing)
                        flag_error($sformatf("word %0d still_playing got %0b expected %0b",
                                             compared, result.still_playing,
                                             want.still_playing));
                    compared++;
                end
            end

            // an input word sees the registers as they were before this edge
            if (item.valid && item.ready)
                predict_word(item.mode, item.pcm_sample);

            // register port: track writes, check read data
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_idx_t'(paddr[3:2]))
                        REG_SOURCE: source_sel = pwdata[1:0];
                        REG_VOLUME: volume = (pwdata[6:0] > VOL_FULL) ? VOL_FULL
                                                                       : pwdata[6:0];
                        REG_FREQ:   tone_freq = pwdata[11:0];
                        default:    play_len = pwdata[COUNT_WIDTH_DEF-1:0];
                    endcase
                end
                else if (prdata !== reg_value(paddr[3:2]))
                begin
                    flag_error($sformatf("register read at 0x%0h got 0x%0h expected 0x%0h",
                                         paddr, prdata, reg_value(paddr[3:2])));
                end
            end

            errors        <= mismatch_count;
            pending       <= expected_words.size();
            words_checked <= compared;
        end
    end

endmodule

// ===== tb/sv/tone_and_pcm_dac_sample_generator_core_tb.sv =====
// tone_and_pcm_dac_sample_generator_core_tb: drives input words, register
// settings and result back-pressure; the checker does the comparing.
// Depends on tpdac_pkg, the channel interfaces, tpdac_sample_checker and the core.
module tone_and_pcm_dac_sample_generator_core_tb;
    import tpdac_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         WORD_TARGET = 800;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] SRC_UNUSED  = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int words_checked;
    int words_sent       = 0;
    int settings_applied = 0;
    int sink_hold        = 0;  // long result hold-off, counted down by the sink
    bit calm             = 1'b0;  // no idling on either side
    bit src_gappy        = 1'b0;

    tpdac_in_if  item_ch();
    tpdac_out_if result_ch();

    tone_and_pcm_dac_sample_generator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tpdac_sample_checker sample_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_ch),
        .result        (result_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // offer one word and hold it until taken, then maybe go idle for a burst
    task automatic send_word(input logic [1:0] mode, input logic [11:0] pcm);
        item_ch.mode       <= mode;
        item_ch.pcm_sample <= pcm;
        item_ch.valid      <= 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (mode != MODE_UNUSED)
            words_sent++;
        if (src_gappy && !calm && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // stop sending until every expected word is back and the core is idle
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // one APB transfer; psel stays high so transfers can run back to back
    task automatic apb_access(input logic is_write, input reg_idx_t idx,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // write all four registers, then read them back
    task automatic apply_settings(input logic [31:0] src, input logic [31:0] vol,
                                  input logic [31:0] freq, input logic [31:0] len);
        reg_idx_t idx;
        apb_access(1'b1, REG_SOURCE, src);
        apb_access(1'b1, REG_VOLUME, vol);
        apb_access(1'b1, REG_FREQ, freq);
        apb_access(1'b1, REG_PLAY, len);
        idx = idx.first();
        repeat (4)
        begin
            apb_access(1'b0, idx, 32'h0);
            idx = idx.next();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // result sink: bursty stalls, quiet windows, and the long hold-off
    initial
    begin
        int stall_left;
        int window;
        bit stalling;
        stall_left = 0;
        window     = 0;
        stalling   = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                stalling = ($urandom_range(0, 2) != 0);
                window   = 64;
            end
            window--;
            if (sink_hold > 0)
            begin
                sink_hold--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && stalling && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] src_w;
        logic [31:0] vol_w;
        logic [31:0] freq_w;
        logic [31:0] len_w;
        int          seg;
        int          n;
        int          r;

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.mode       <= MODE_TICK;
        item_ch.pcm_sample <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle core: tick, stop and a dropped mode
        send_word(MODE_TICK, 12'hFFF);
        send_word(MODE_STOP, 12'h000);
        send_word(MODE_UNUSED, 12'hABC);
        drain_results();

        // 12-bit PCM at full gain: range ends, midpoint, end of playback
        apply_settings(32'(SRC_PCM12), 32'(VOL_FULL), 32'h0, 32'd4);
        send_word(MODE_START, 12'h000);
        send_word(MODE_TICK, 12'h000);
        send_word(MODE_TICK, 12'hFFF);
        send_word(MODE_TICK, 12'h800);
        send_word(MODE_UNUSED, 12'h555);
        send_word(MODE_TICK, 12'h7FF);
        send_word(MODE_TICK, 12'h123);
        drain_results();

        // length masks to zero: start is dropped
        apply_settings(32'(SRC_PCM8), 32'h0, 32'hFFFF_FFFF, 32'h0100_0000);
        send_word(MODE_START, 12'hFFF);
        send_word(MODE_TICK, 12'hFFF);
        drain_results();

        // 8-bit PCM, volume write above 100, restart and stop while playing
        apply_settings(32'(SRC_PCM8), 32'hFF, 32'd4000, 32'd3);
        send_word(MODE_START, 12'h000);
        send_word(MODE_TICK, 12'hF00);
        send_word(MODE_TICK, 12'h0FF);
        send_word(MODE_START, 12'h000);
        send_word(MODE_STOP, 12'hFFF);
        send_word(MODE_TICK, 12'h0FF);
        drain_results();

        // unused source still counts down
        apply_settings(32'(SRC_UNUSED), 32'd1, 32'h0, 32'd2);
        send_word(MODE_START, 12'h000);
        send_word(MODE_TICK, 12'hFFF);
        send_word(MODE_TICK, 12'h000);
        send_word(MODE_TICK, 12'hFFF);
        drain_results();

        // sine with zero frequency (step 1), longest length, then stop
        apply_settings(32'(SRC_SINE), 32'h0000_01E5, 32'h0, 32'hFFFF_FFFF);
        send_word(MODE_START, 12'h000);
        send_word(MODE_TICK, 12'hFFF);
        send_word(MODE_TICK, 12'h000);
        send_word(MODE_STOP, 12'h000);
        drain_results();

        // fastest tone, long enough to pass both odd table entries
        src_gappy = 1'b1;
        apply_settings(32'(SRC_SINE), 32'(VOL_FULL), 32'd4095, 32'd380);
        send_word(MODE_START, 12'($urandom_range(0, 4095)));
        repeat (384)
            send_word(MODE_TICK, 12'($urandom_range(0, 4095)));
        drain_results();

        // random settings, each followed by a playback sequence
        seg = 0;
        while (words_sent < WORD_TARGET)
        begin
            calm      = (words_sent >= WORD_TARGET - 100);
            src_gappy = ($urandom_range(0, 2) != 0);

            r = $urandom_range(0, 9);
            src_w = (r < 3) ? 32'(SRC_SINE) : (r < 6) ? 32'(SRC_PCM8)
                  : (r < 9) ? 32'(SRC_PCM12) : 32'(SRC_UNUSED);
            case ($urandom_range(0, 5))
                0:       vol_w = 32'h0;
                1:       vol_w = 32'(VOL_FULL);
                2:       vol_w = $urandom;
                default: vol_w = $urandom_range(0, 100);
            endcase
            case ($urandom_range(0, 4))
                0:       freq_w = 32'h0;
                1:       freq_w = 32'd4095;
                2:       freq_w = $urandom;
                default: freq_w = $urandom_range(1, 4000);
            endcase
            case ($urandom_range(0, 9))
                0:       len_w = 32'h0;
                1:       len_w = $urandom;
                2:       len_w = 32'h00FF_FFFF;
                default: len_w = $urandom_range(1, 40);
            endcase
            apply_settings(src_w, vol_w, freq_w, len_w);

            // one segment runs against a long result hold-off
            if (seg == 2)
            begin
                src_gappy = 1'b0;
                sink_hold = 48;
            end

            n = $urandom_range(12, 45);
            send_word(MODE_START, 12'($urandom_range(0, 4095)));
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 86)
                    send_word(MODE_TICK, 12'($urandom_range(0, 4095)));
                else if (r < 91)
                    send_word(MODE_START, 12'($urandom_range(0, 4095)));
                else if (r < 95)
                    send_word(MODE_STOP, 12'($urandom_range(0, 4095)));
                else
                    send_word(MODE_UNUSED, 12'($urandom_range(0, 4095)));
            end
            drain_results();
            seg++;
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d input words under %0d register settings; %0d result words compared.",
                 words_sent, settings_applied, words_checked);
        $display("Covered a full sine sweep, 8/12-bit PCM, unused source, starts, stops.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tpdac_pkg.sv
sv/tpdac_in_if.sv
sv/tpdac_out_if.sv
sv/tpdac_scale.sv
sv/tone_and_pcm_dac_sample_generator_core.sv
tb/sv/tpdac_sample_checker.sv
tb/sv/tone_and_pcm_dac_sample_generator_core_tb.sv
